// File: sv/rtp_header_parser_assert.svh
// Assertion macros for the RTP header parser.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef RTP_HEADER_PARSER_ASSERT_SVH
`define RTP_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication.
`define RHP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rtp_header_parser: same-cycle check failed");

// Next-cycle implication.
`define RHP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rtp_header_parser: next-cycle check failed");

`endif

// File: sv/rtp_hp_pkg.sv
package rtp_hp_pkg;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_CSRC    = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // fixed header length in bytes, and its last index
  localparam int unsigned HdrBytes = 12;
  localparam logic [3:0]  HDR_LAST_POS = 4'(HdrBytes - 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  version;
    logic        padding_flag;
    logic        extension_flag;
    logic        marker;
    logic [6:0]  payload_type;
    logic [15:0] seq_number;
    logic [31:0] timestamp;
    logic [31:0] sync_source;
    logic [3:0]  csrc_count;
    logic [31:0] data_word;
    logic        out_last;
  } out_word_t;

endpackage

// File: sv/rtp_header_parser.sv
// RTP header parser (RFC 3550). Takes a packet one byte per input word,
// in_last set on the final byte, and reads multi-byte fields big-endian.
// After the 12 fixed bytes it gives one header word (V, P, X, M, PT,
// sequence, timestamp, SSRC, CC), then one word per CSRC, skips the
// header extension only when X is set (profile, length in 32-bit words,
// data), and passes every further byte on as a payload word. Padding is
// not stripped. A packet that ends inside the header, CSRC list or
// extension gives a single error word with out_last set; a packet that
// ends exactly at the end of the extension gives nothing for that byte.
// Rate: one input byte per clock, sustained. Each byte is decoded by a
// single pass of logic from the parse state into one result register, so
// a byte is taken whenever that register is empty or being emptied in
// the same cycle; the result is registered there in the cycle after. The result
// register is the only buffer, so a stalled output stalls the input.
module rtp_header_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rtp_hp_pkg::in_word_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rtp_hp_pkg::out_word_t out_data_o
);

`include "rtp_header_parser_assert.svh"

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_CSRC = 3'd1,
    PH_EXTH = 3'd2,
    PH_EXTD = 3'd3,
    PH_PAY  = 3'd4
  } phase_e;

  // parse state
  phase_e      phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;          // byte index within header or word
  logic [31:0] shift_q, shift_d;      // CSRC / extension word assembly
  logic [3:0]  csrc_left_q, csrc_left_d;
  logic [17:0] ext_left_q, ext_left_d; // extension data bytes still to skip
  logic [15:0] first_q, first_d;      // header bytes 0 and 1
  logic [15:0] seq_q, seq_d;
  logic [31:0] ts_q, ts_d;
  logic [31:0] ssrc_q, ssrc_d;

  // result register
  logic                  out_valid_q, out_valid_d;
  rtp_hp_pkg::out_word_t out_q, out_d;

  // decode of the current byte
  rtp_hp_pkg::out_word_t res;
  logic                  res_valid;
  logic                  in_fire;
  logic [7:0]            in_b;
  logic                  in_l;
  logic [31:0]           shifted;
  logic [3:0]            pos_inc;
  logic [3:0]            hdr_pos;
  logic [3:0]            cc;
  logic                  x_hdr;
  logic [3:0]            csrc_dec;
  logic [17:0]           ext_dec;
  logic [17:0]           ext_len;

  // Result register frees up when it is empty or being read this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign in_b     = in_data_i.in_byte;
  assign in_l     = in_data_i.in_last;
  assign shifted  = {shift_q[23:0], in_b};
  assign pos_inc  = pos_q + 4'd1;
  assign hdr_pos  = (pos_q > rtp_hp_pkg::HDR_LAST_POS) ? 4'd0 : pos_q;
  assign cc       = first_q[11:8];
  assign x_hdr    = first_q[12];
  assign csrc_dec = csrc_left_q - 4'd1;
  assign ext_dec  = ext_left_q - 18'd1;
  assign ext_len  = {shifted[15:0], 2'b00};

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    shift_d     = shift_q;
    csrc_left_d = csrc_left_q;
    ext_left_d  = ext_left_q;
    first_d     = first_q;
    seq_d       = seq_q;
    ts_d        = ts_q;
    ssrc_d      = ssrc_q;
    res         = '0;
    res_valid   = 1'b0;

    case (phase_q)
      PH_CSRC: begin
        shift_d = shifted;
        pos_d   = pos_inc;
        if (pos_inc[3:2] == 2'b00) begin
          if (in_l) begin
            res_valid = 1'b1;
          end
        end else begin
          pos_d       = 4'd0;
          csrc_left_d = csrc_dec;
          if (in_l && (csrc_dec != 4'd0 || x_hdr)) begin
            res_valid = 1'b1;
          end else begin
            res_valid      = 1'b1;
            res.kind       = rtp_hp_pkg::KIND_CSRC;
            res.data_word  = shifted;
            res.out_last   = in_l;
            if (in_l) begin
              phase_d = PH_HDR;
            end else if (csrc_dec != 4'd0) begin
              phase_d = PH_CSRC;
            end else if (x_hdr) begin
              phase_d = PH_EXTH;
            end else begin
              phase_d = PH_PAY;
            end
          end
        end
        if (res_valid && res.kind != rtp_hp_pkg::KIND_CSRC) begin
          res.kind     = rtp_hp_pkg::KIND_ERROR;
          res.out_last = 1'b1;
          phase_d      = PH_HDR;
          pos_d        = 4'd0;
        end
      end

      PH_EXTH: begin
        shift_d = shifted;
        pos_d   = pos_inc;
        if (pos_inc[3:2] == 2'b00) begin
          if (in_l) begin
            res_valid    = 1'b1;
            res.kind     = rtp_hp_pkg::KIND_ERROR;
            res.out_last = 1'b1;
            phase_d      = PH_HDR;
            pos_d        = 4'd0;
          end
        end else begin
          pos_d      = 4'd0;
          ext_left_d = ext_len;
          if (in_l) begin
            phase_d = PH_HDR;
            if (ext_len != 18'd0) begin
              res_valid    = 1'b1;
              res.kind     = rtp_hp_pkg::KIND_ERROR;
              res.out_last = 1'b1;
            end
          end else begin
            phase_d = (ext_len != 18'd0) ? PH_EXTD : PH_PAY;
          end
        end
      end

      PH_EXTD: begin
        ext_left_d = ext_dec;
        if (in_l) begin
          phase_d = PH_HDR;
          pos_d   = 4'd0;
          if (ext_dec != 18'd0) begin
            res_valid    = 1'b1;
            res.kind     = rtp_hp_pkg::KIND_ERROR;
            res.out_last = 1'b1;
          end
        end else if (ext_dec == 18'd0) begin
          phase_d = PH_PAY;
        end
      end

      PH_PAY: begin
        res_valid     = 1'b1;
        res.kind      = rtp_hp_pkg::KIND_PAYLOAD;
        res.data_word = {24'd0, in_b};
        res.out_last  = in_l;
        if (in_l) begin
          phase_d = PH_HDR;
          pos_d   = 4'd0;
        end
      end

      default: begin
        // fixed header; unused phase codes land here too
        phase_d = PH_HDR;
        if (hdr_pos < 4'd2) begin
          first_d = {first_q[7:0], in_b};
        end else if (hdr_pos < 4'd4) begin
          seq_d = {seq_q[7:0], in_b};
        end else if (hdr_pos < 4'd8) begin
          ts_d = {ts_q[23:0], in_b};
        end else begin
          ssrc_d = {ssrc_q[23:0], in_b};
        end

        if (hdr_pos != rtp_hp_pkg::HDR_LAST_POS) begin
          pos_d = hdr_pos + 4'd1;
          if (in_l) begin
            res_valid    = 1'b1;
            res.kind     = rtp_hp_pkg::KIND_ERROR;
            res.out_last = 1'b1;
            pos_d        = 4'd0;
          end
        end else begin
          // last header byte: bytes 0 and 1 are already held
          pos_d     = 4'd0;
          res_valid = 1'b1;
          if (in_l && (cc != 4'd0 || x_hdr)) begin
            res.kind     = rtp_hp_pkg::KIND_ERROR;
            res.out_last = 1'b1;
          end else begin
            res.kind           = rtp_hp_pkg::KIND_HEADER;
            res.version        = first_q[15:14];
            res.padding_flag   = first_q[13];
            res.extension_flag = x_hdr;
            res.marker         = first_q[7];
            res.payload_type   = first_q[6:0];
            res.seq_number     = seq_q;
            res.timestamp      = ts_q;
            res.sync_source    = ssrc_d;
            res.csrc_count     = cc;
            res.out_last       = in_l;
            csrc_left_d        = cc;
            shift_d            = '0;
            if (in_l) begin
              phase_d = PH_HDR;
            end else if (cc != 4'd0) begin
              phase_d = PH_CSRC;
            end else if (x_hdr) begin
              phase_d = PH_EXTH;
            end else begin
              phase_d = PH_PAY;
            end
          end
        end
      end
    endcase
  end

  // result register: load on a decoded result, drain on out_ready
  always_comb begin
    out_d = out_q;
    if (in_fire) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_d = res;
      end
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HDR;
      pos_q       <= '0;
      shift_q     <= '0;
      csrc_left_q <= '0;
      ext_left_q  <= '0;
      first_q     <= '0;
      seq_q       <= '0;
      ts_q        <= '0;
      ssrc_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        shift_q     <= shift_d;
        csrc_left_q <= csrc_left_d;
        ext_left_q  <= ext_left_d;
        first_q     <= first_d;
        seq_q       <= seq_d;
        ts_q        <= ts_d;
        ssrc_q      <= ssrc_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // error words always close the packet
  `RHP_ASSERT_IMP(a_err_last, out_valid_o && out_data_o.kind == rtp_hp_pkg::KIND_ERROR, out_data_o.out_last)
  // a final byte always leaves the parser at the start of a header
  `RHP_ASSERT_NXT(a_last_resync, in_fire && in_data_i.in_last, phase_q == PH_HDR && pos_q == 4'd0)
  // CSRC phase only with words still owed
  `RHP_ASSERT_IMP(a_csrc_left, phase_q == PH_CSRC, csrc_left_q != 4'd0)
  // extension data phase only with bytes still to skip
  `RHP_ASSERT_IMP(a_ext_left, phase_q == PH_EXTD, ext_left_q != 18'd0)
  // outside the header the byte index never leaves a 32-bit word
  `RHP_ASSERT_IMP(a_pos_word, phase_q != PH_HDR, pos_q[3:2] == 2'b00)

endmodule
